// ===== sv/pse_pkg.sv =====
// Shared types and constants for the postfix stack evaluator.
// Holds operation and status codes and the controller/datapath command
// and status structs; depends on nothing.
package pse_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int DEPTH_W         = 5;
  localparam int OP_W            = 3;
  localparam int STAT_W          = 2;
  localparam int CNT_W           = 5;   // counts the 32 division steps

  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
  localparam logic [OP_W-1:0] OP_POW  = 3'd5;
  localparam logic [OP_W-1:0] OP_DUMP = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNDER   = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVER    = 2'd2;
  localparam logic [STAT_W-1:0] ST_DIVZERO = 2'd3;

  // Source of an emitted result value
  localparam logic [1:0] SEL_TOP  = 2'd0;   // top entry, zero when empty
  localparam logic [1:0] SEL_OPND = 2'd1;   // pushed operand
  localparam logic [1:0] SEL_ACC  = 2'd2;   // arithmetic result

  typedef struct packed {
    logic              load;        // latch operand, read the two top entries
    logic              push;        // write operand at top, grow by one
    logic              alu;         // add, sub or mul into accumulator
    logic [OP_W-1:0]   op;
    logic              div_init;
    logic              div_step;
    logic              div_fix;
    logic              pow_init;
    logic              pow_step;
    logic              commit;      // write accumulator, shrink by one
    logic              idx_clr;
    logic              dump_rd;     // read entry at dump index
    logic              idx_inc;
    logic              emit;
    logic [1:0]        emit_sel;
    logic [STAT_W-1:0] emit_status;
    logic              emit_last;
  } cmd_t;

  typedef struct packed {
    logic sp_zero;
    logic sp_lt2;
    logic full;
    logic b_zero;
    logic exp_zero;
    logic cnt_last;
    logic idx_last;
  } stat_t;

endpackage

// ===== sv/pse_ctrl.sv =====
// Controller state machine for the postfix stack evaluator.
// Decodes each accepted item and sequences the datapath; uses pse_pkg.
module pse_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pse_pkg::OP_W-1:0]   operation,
  input  pse_pkg::stat_t             stat,
  output pse_pkg::cmd_t              cmd,
  output logic                       busy
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_DIV      = 3'd2;
  localparam logic [2:0] S_DIV_FIX  = 3'd3;
  localparam logic [2:0] S_POW      = 3'd4;
  localparam logic [2:0] S_COMMIT   = 3'd5;
  localparam logic [2:0] S_DUMP_RD  = 3'd6;
  localparam logic [2:0] S_DUMP_OUT = 3'd7;

  logic [2:0]                 state;
  logic [2:0]                 state_next;
  logic [pse_pkg::OP_W-1:0]   op_q;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_q <= operation;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.op      = op_q;
    cmd.emit_status = pse_pkg::ST_OK;
    cmd.emit_sel    = pse_pkg::SEL_TOP;
    cmd.emit_last   = 1'b1;
    state_next  = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        if (op_q == pse_pkg::OP_PUSH) begin
          cmd.emit = 1'b1;
          if (stat.full) begin
            cmd.emit_status = pse_pkg::ST_OVER;
          end else begin
            cmd.push     = 1'b1;
            cmd.emit_sel = pse_pkg::SEL_OPND;
          end
        end else if (op_q == pse_pkg::OP_DUMP) begin
          if (stat.sp_zero) begin
            cmd.emit = 1'b1;
          end else begin
            cmd.idx_clr = 1'b1;
            state_next  = S_DUMP_RD;
          end
        end else if (op_q > pse_pkg::OP_DUMP) begin
          cmd.emit = 1'b1;
        end else if (stat.sp_lt2) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = pse_pkg::ST_UNDER;
        end else if (op_q == pse_pkg::OP_DIV) begin
          if (stat.b_zero) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = pse_pkg::ST_DIVZERO;
          end else begin
            cmd.div_init = 1'b1;
            state_next   = S_DIV;
          end
        end else if (op_q == pse_pkg::OP_POW) begin
          cmd.pow_init = 1'b1;
          state_next   = S_POW;
        end else begin
          cmd.alu    = 1'b1;
          state_next = S_COMMIT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.cnt_last) begin
          state_next = S_DIV_FIX;
        end
      end
      S_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        state_next  = S_COMMIT;
      end
      S_POW: begin
        if (stat.exp_zero) begin
          state_next = S_COMMIT;
        end else begin
          cmd.pow_step = 1'b1;
        end
      end
      S_COMMIT: begin
        cmd.commit   = 1'b1;
        cmd.emit     = 1'b1;
        cmd.emit_sel = pse_pkg::SEL_ACC;
        state_next   = S_IDLE;
      end
      S_DUMP_RD: begin
        cmd.dump_rd = 1'b1;
        state_next  = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        cmd.emit      = 1'b1;
        cmd.emit_last = stat.idx_last;
        cmd.idx_inc   = 1'b1;
        state_next    = stat.idx_last ? S_IDLE : S_DUMP_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Only the decode, commit and dump output states may emit a result
  a_emit_state: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (state == S_DECODE || state == S_COMMIT || state == S_DUMP_OUT))
    else $error("result emitted from a working state");

  // An item is latched only while idle, and latching always moves to decode
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_DECODE))
    else $error("load did not advance to decode");

  // Division always runs through its sign fix before commit
  a_div_fix: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && stat.cnt_last) |=> (state == S_DIV_FIX))
    else $error("division skipped sign fix");

endmodule

// ===== sv/pse_datapath.sv =====
// Datapath for the postfix stack evaluator: stack memory, stack pointer,
// serial divider, square-and-multiply power unit and result registers.
// Driven by pse_ctrl commands; uses pse_pkg.
module pse_datapath #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic signed [pse_pkg::DATA_W-1:0] operand,
  input  pse_pkg::cmd_t                  cmd,
  output pse_pkg::stat_t                 stat,
  output logic                           strobe,
  output logic signed [pse_pkg::DATA_W-1:0] result_value,
  output logic [pse_pkg::DEPTH_W-1:0]    stack_depth,
  output logic [pse_pkg::STAT_W-1:0]     status,
  output logic                           last
);

  localparam int DW = pse_pkg::DATA_W;
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PW = $clog2(STACK_DEPTH + 1);

  logic [DW-1:0] mem [STACK_DEPTH];
  logic [DW-1:0] rd_top;
  logic [DW-1:0] rd_nxt;
  logic [PW-1:0] sp;
  logic [PW-1:0] sp_next;
  logic [PW-1:0] sp_m1;
  logic [PW-1:0] sp_m2;
  logic [PW-1:0] idx;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic          wr_en;

  logic [DW-1:0]        opnd;
  logic [DW-1:0]        acc;    // result / quotient / power product
  logic [DW-1:0]        aux;    // remainder / power base
  logic [DW-1:0]        ereg;   // divisor / exponent
  logic                 neg;
  logic [pse_pkg::CNT_W-1:0] cnt;

  logic [2*DW-1:0] prod_ab;
  logic [2*DW-1:0] prod_acc;
  logic [2*DW-1:0] prod_sq;
  logic [DW:0]     trial;
  logic [DW-1:0]   mag_a;
  logic [DW-1:0]   mag_b;
  logic [DW-1:0]   emit_val;

  assign sp_m1 = sp - PW'(1);
  assign sp_m2 = sp - PW'(2);

  // Port A follows the dump index during a dump, otherwise the top entry
  assign rd_addr = cmd.dump_rd ? idx[AW-1:0] : sp_m1[AW-1:0];

  assign wr_en   = cmd.push | cmd.commit;
  assign wr_addr = cmd.push ? sp[AW-1:0] : sp_m2[AW-1:0];
  assign wr_data = cmd.push ? opnd : acc;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_top <= mem[rd_addr];
    rd_nxt <= mem[sp_m2[AW-1:0]];
  end

  always_comb begin
    sp_next = sp;
    if (cmd.push) begin
      sp_next = sp + PW'(1);
    end else if (cmd.commit) begin
      sp_next = sp_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else begin
      sp <= sp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opnd <= operand;
    end
  end

  // Left operand is the lower entry, right operand the top
  assign prod_ab  = rd_nxt * rd_top;
  assign prod_acc = acc * aux;
  assign prod_sq  = aux * aux;
  assign mag_a    = rd_nxt[DW-1] ? (DW'(0) - rd_nxt) : rd_nxt;
  assign mag_b    = rd_top[DW-1] ? (DW'(0) - rd_top) : rd_top;
  assign trial    = {aux, acc[DW-1]} - {1'b0, ereg};

  always_ff @(posedge clk) begin
    if (cmd.alu) begin
      case (cmd.op)
        pse_pkg::OP_ADD: acc <= rd_nxt + rd_top;
        pse_pkg::OP_SUB: acc <= rd_nxt - rd_top;
        default:         acc <= prod_ab[DW-1:0];
      endcase
    end else if (cmd.div_init) begin
      acc  <= mag_a;
      aux  <= '0;
      ereg <= mag_b;
      neg  <= rd_nxt[DW-1] ^ rd_top[DW-1];
    end else if (cmd.div_step) begin
      // Restoring step: shift one dividend bit into the remainder
      if (!trial[DW]) begin
        aux <= trial[DW-1:0];
        acc <= {acc[DW-2:0], 1'b1};
      end else begin
        aux <= {aux[DW-2:0], acc[DW-1]};
        acc <= {acc[DW-2:0], 1'b0};
      end
    end else if (cmd.div_fix) begin
      acc <= neg ? (DW'(0) - acc) : acc;
    end else if (cmd.pow_init) begin
      acc  <= DW'(1);
      aux  <= rd_nxt;
      // Negative exponent gives one: start with nothing left to do
      ereg <= rd_top[DW-1] ? '0 : rd_top;
    end else if (cmd.pow_step) begin
      if (ereg[0]) begin
        acc <= prod_acc[DW-1:0];
      end
      aux  <= prod_sq[DW-1:0];
      ereg <= {1'b0, ereg[DW-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      cnt <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + pse_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    case (cmd.emit_sel)
      pse_pkg::SEL_OPND: emit_val = opnd;
      pse_pkg::SEL_ACC:  emit_val = acc;
      default:           emit_val = (sp == '0) ? '0 : rd_top;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_value <= emit_val;
      stack_depth  <= pse_pkg::DEPTH_W'(sp_next);
      status       <= cmd.emit_status;
      last         <= cmd.emit_last;
    end
  end

  assign stat.sp_zero  = (sp == '0);
  assign stat.sp_lt2   = (sp < PW'(2));
  assign stat.full     = (sp == PW'(STACK_DEPTH));
  assign stat.b_zero   = (rd_top == '0);
  assign stat.exp_zero = (ereg == '0);
  assign stat.cnt_last = (cnt == '1);
  assign stat.idx_last = ((idx + PW'(1)) == sp);

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= PW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.commit))
    else $error("push and commit in the same cycle");

  a_fault_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && status != pse_pkg::ST_OK) |-> last)
    else $error("faulted result not marked last");

  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> (sp == $past(sp) + PW'(1)))
    else $error("push did not grow the stack");

endmodule

// ===== sv/postfix_stack_evaluator.sv =====
// Postfix stack evaluator: an item is taken when start is high and busy is
// low. The caller cannot stall results: each one shows on the result ports
// for a single cycle with strobe high and must be captured then. An item is
// latched while idle and decoded; push, fault and unused codes emit from
// decode, add, sub and mul go to commit, divide runs the one-bit-per-cycle
// restoring divider over 32 quotient bits, a sign fix and commit, and power
// runs one square-and-multiply step per exponent bit up to its highest set
// bit, then commit. A dump reads each entry through its single dump read
// port and then shows it, so a stack of N entries streams N transfers, the
// last one with last high; an empty stack gives one zero result. busy drops
// as the final result is launched, so the next item can be taken while it
// is shown. Depends on pse_pkg, pse_ctrl and pse_datapath.
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [pse_pkg::OP_W-1:0]           operation,
  input  logic signed [pse_pkg::DATA_W-1:0]  operand,
  output logic                               strobe,
  output logic signed [pse_pkg::DATA_W-1:0]  result_value,
  output logic [pse_pkg::DEPTH_W-1:0]        stack_depth,
  output logic [pse_pkg::STAT_W-1:0]         status,
  output logic                               last
);

  pse_pkg::cmd_t  cmd;
  pse_pkg::stat_t stat;

  // Sequence each item: decode, iterate the arithmetic, commit or dump
  pse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Hold the stack, run the arithmetic and drive every result transfer
  pse_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .operand      (operand),
    .cmd          (cmd),
    .stat         (stat),
    .strobe       (strobe),
    .result_value (result_value),
    .stack_depth  (stack_depth),
    .status       (status),
    .last         (last)
  );

endmodule
